>>> rtl/fk_pkg.sv
// ----------------------------------------------------------------------------
// fk_pkg
// Shared types, constants and arithmetic helpers for the six-axis forward
// kinematics pipeline.
// ----------------------------------------------------------------------------
package fk_pkg;

   // Number of register stages from the input phase register to the pose output register.
   localparam int PIPE_DEPTH = 13;
   localparam int PIPE_LAST  = PIPE_DEPTH - 1;

   // Phase of one full turn is 2^18.
   typedef logic [17:0] phase_type;
   localparam phase_type QUARTER = 18'h10000;

   // Signed Q30 working value, wide enough for every sum in the pose equations.
   typedef logic signed [33:0] q_type;

   // Unsigned Horner accumulator of the quarter-wave polynomial.
   typedef logic [30:0] horner_type;

   localparam horner_type TRIG_C1 = 31'd1686629713;
   localparam horner_type TRIG_C3 = 31'd693598668;
   localparam horner_type TRIG_C5 = 31'd85569306;
   localparam horner_type TRIG_C7 = 31'd5026995;
   localparam horner_type TRIG_C9 = 31'd172272;

   // Link lengths as ratios of the summed length, Q30, rounded to nearest.
   localparam q_type K_D1 = q_type'((64'sd125 * 64'sd1073741824 + 64'sd293) / 64'sd587);
   localparam q_type K_A2 = q_type'((64'sd150 * 64'sd1073741824 + 64'sd293) / 64'sd587);
   localparam q_type K_D4 = q_type'((64'sd192 * 64'sd1073741824 + 64'sd293) / 64'sd587);
   localparam q_type K_D6 = q_type'((64'sd120 * 64'sd1073741824 + 64'sd293) / 64'sd587);

   typedef struct packed {
      logic signed [15:0] joint_one;
      logic signed [15:0] joint_two;
      logic signed [15:0] joint_three;
      logic signed [15:0] joint_four;
      logic signed [15:0] joint_five;
      logic signed [15:0] joint_six;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] slide_x;
      logic signed [15:0] slide_y;
      logic signed [15:0] slide_z;
      logic signed [15:0] approach_x;
      logic signed [15:0] approach_y;
      logic signed [15:0] approach_z;
   } rsp_type;

   // Sines and cosines of the six joints and of the shoulder-elbow sum.
   typedef struct packed {
      q_type s1;  q_type c1;
      q_type s2;  q_type c2;
      q_type s3;  q_type c3;
      q_type s4;  q_type c4;
      q_type s5;  q_type c5;
      q_type s6;  q_type c6;
      q_type s23; q_type c23;
   } trig_type;

   // Q30 product, floored back to Q30.
   function automatic q_type mq(input q_type a, input q_type b);
      logic signed [67:0] p;
      p = 68'(a) * 68'(b);
      return q_type'(p >>> 30);
   endfunction

   // One Horner step: c - ((r * x2) >> 16).
   function automatic horner_type horner(input horner_type c, input horner_type r,
                                         input logic [16:0] x2);
      logic [47:0] p;
      p = {17'd0, r} * {31'd0, x2};
      return c - p[46:16];
   endfunction

   // Q30 to Q15 with round half up and saturation.
   function automatic logic signed [15:0] to_q15(input q_type v);
      logic signed [34:0] t;
      t = (35'(v) + 35'sd16384) >>> 15;
      if (t > 35'sd32767) begin
         return 16'sh7fff;
      end
      if (t < -35'sd32768) begin
         return -16'sh8000;
      end
      return t[15:0];
   endfunction

endpackage

>>> rtl/fk_req_if.sv
// ----------------------------------------------------------------------------
// fk_req_if
// Joint command channel: valid, ready and one joint vector.
// ----------------------------------------------------------------------------
interface fk_req_if;
   logic            valid;
   logic            ready;
   fk_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/fk_rsp_if.sv
// ----------------------------------------------------------------------------
// fk_rsp_if
// Pose result channel: valid, ready and one pose.
// ----------------------------------------------------------------------------
interface fk_rsp_if;
   logic            valid;
   logic            ready;
   fk_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/fk_sincos.sv
// ----------------------------------------------------------------------------
// fk_sincos
// Six-stage pipelined sine of an 18-bit phase by a quarter-wave polynomial.
// ----------------------------------------------------------------------------
module fk_sincos (
   input  logic              clock,
   input  logic              adv,
   input  fk_pkg::phase_type phase,
   output fk_pkg::q_type     value
);

   logic [1:0]  quad;
   logic [16:0] f_in;
   logic [33:0] sq;

   logic [16:0]        f_ff   [5];
   logic [16:0]        x2_ff  [4];
   logic               neg_ff [5];
   fk_pkg::horner_type r_ff   [4];
   logic [47:0]        prod;
   fk_pkg::q_type      mag;
   fk_pkg::q_type      value_ff;

   assign quad = phase[17:16];
   // Odd quadrants run the quarter wave backwards.
   assign f_in = quad[0] ? (17'h10000 - {1'b0, phase[15:0]}) : {1'b0, phase[15:0]};
   assign sq   = {17'd0, f_in} * {17'd0, f_in};

   assign prod = {17'd0, r_ff[3]} * {31'd0, f_ff[4]};
   assign mag  = fk_pkg::q_type'({2'b00, prod[47:16]});

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff[0]   <= f_in;
         x2_ff[0]  <= sq[32:16];
         neg_ff[0] <= quad[1];

         r_ff[0]   <= fk_pkg::horner(fk_pkg::TRIG_C7, fk_pkg::TRIG_C9, x2_ff[0]);
         f_ff[1]   <= f_ff[0];
         x2_ff[1]  <= x2_ff[0];
         neg_ff[1] <= neg_ff[0];

         r_ff[1]   <= fk_pkg::horner(fk_pkg::TRIG_C5, r_ff[0], x2_ff[1]);
         f_ff[2]   <= f_ff[1];
         x2_ff[2]  <= x2_ff[1];
         neg_ff[2] <= neg_ff[1];

         r_ff[2]   <= fk_pkg::horner(fk_pkg::TRIG_C3, r_ff[1], x2_ff[2]);
         f_ff[3]   <= f_ff[2];
         x2_ff[3]  <= x2_ff[2];
         neg_ff[3] <= neg_ff[2];

         r_ff[3]   <= fk_pkg::horner(fk_pkg::TRIG_C1, r_ff[2], x2_ff[3]);
         f_ff[4]   <= f_ff[3];
         neg_ff[4] <= neg_ff[3];

         value_ff  <= neg_ff[4] ? -mag : mag;
      end
   end

   assign value = value_ff;

endmodule

>>> rtl/fk_pose.sv
// ----------------------------------------------------------------------------
// fk_pose
// Six-stage pipeline evaluating the closed-form arm equations from the joint
// sines and cosines, with one product level per stage and a final rounding.
// ----------------------------------------------------------------------------
module fk_pose (
   input  logic             clock,
   input  logic             adv,
   input  fk_pkg::trig_type tr,
   output fk_pkg::rsp_type  pose
);

   // First product level.
   fk_pkg::trig_type tr1_ff, tr2_ff, tr3_ff;
   fk_pkg::q_type    s5_4_ff;
   fk_pkg::q_type reach_ff, m_s1s4_ff, m_c5s23_ff, m_c23c4_ff, m_c5s1_ff, m_c1s4_ff;
   fk_pkg::q_type m_c23c5_ff, m_c4s23_ff, m_c6s23_ff, m_c4c5_ff, m_c23s5_ff, m_c4s1_ff;
   fk_pkg::q_type m_c1c23_ff, m_s23s5_ff, m_c4c6_ff, m_c5s4_ff, m_c6s4_ff, m_c4s5_ff;
   fk_pkg::q_type m_d6s1_ff, m_a2c2_ff, m_d6c23_ff, m_c2s1_ff, m_d6c3_ff, m_a2s2_ff;
   fk_pkg::q_type m_d6c4_ff;

   // Second product level.
   fk_pkg::q_type n_s1s4s5_ff, n_c23c4s5_ff, n_c5s1s23_ff, n_c23c4s1_ff, n_c4s23s5_ff;
   fk_pkg::q_type n_c6s23s4_ff, n_c4c5s23_ff, n_c1c23s4_ff, n_c5s1s4_ff, n_c23c4c5_ff;
   fk_pkg::q_type n_c5s4s6_ff, n_s23s5s6_ff, n_c4s5s6_ff, n_d6s1s4_ff, n_rs23_ff;
   fk_pkg::q_type n_d6c23c4_ff, n_c3r_ff, n_c4s1s2_ff, n_rs3_ff, n_d6c3c4_ff, n_c23r_ff;
   fk_pkg::q_type n_d6c4s23_ff, n_c5s23_ff, n_c1s4_ff, n_c23c5_ff, n_c23s5_ff, n_c4s1_ff;
   fk_pkg::q_type n_s23s5_ff, n_c4c6_ff, n_c6s4_ff, n_a2c2_ff, n_c2s1_ff, n_a2s2_ff;

   // Third product level.
   fk_pkg::q_type o_r6b_ff, o_s1s4s5_ff, o_r7b_ff, o_c5s1s23_ff, o_r8_ff, o_r5b_ff;
   fk_pkg::q_type o_c6s23s4_ff, o_r3a_ff, o_r3c_ff, o_c5s1s4_ff, o_r4a_ff, o_r4c_ff;
   fk_pkg::q_type o_s23s5s6_ff, o_r0a_ff, o_r0c_ff, o_rs23_ff, o_a2c2_ff, o_c3rs1_ff;
   fk_pkg::q_type o_c4s1s2s3_ff, o_c1s4_ff, o_r1c_ff, o_rs3_ff, o_c2s1_ff, o_r2_ff;

   // Fourth and fifth levels.
   fk_pkg::q_type p_r0_ff, p_r2_ff, p_r3_ff, p_r4_ff, p_r5_ff, p_r6_ff, p_r7_ff, p_r8_ff;
   fk_pkg::q_type p_r1a_ff, p_r1b_ff, p_r1c_ff;
   fk_pkg::q_type q_r0_ff, q_r1_ff, q_r2_ff, q_r3_ff, q_r4_ff, q_r5_ff, q_r6_ff, q_r7_ff;
   fk_pkg::q_type q_r8_ff;
   fk_pkg::rsp_type pose_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         tr1_ff     <= tr;
         reach_ff   <= fk_pkg::K_D4 + fk_pkg::mq(fk_pkg::K_D6, tr.c5);
         m_s1s4_ff  <= fk_pkg::mq(tr.s1, tr.s4);
         m_c5s23_ff <= fk_pkg::mq(tr.c5, tr.s23);
         m_c23c4_ff <= fk_pkg::mq(tr.c23, tr.c4);
         m_c5s1_ff  <= fk_pkg::mq(tr.c5, tr.s1);
         m_c1s4_ff  <= fk_pkg::mq(tr.c1, tr.s4);
         m_c23c5_ff <= fk_pkg::mq(tr.c23, tr.c5);
         m_c4s23_ff <= fk_pkg::mq(tr.c4, tr.s23);
         m_c6s23_ff <= fk_pkg::mq(tr.c6, tr.s23);
         m_c4c5_ff  <= fk_pkg::mq(tr.c4, tr.c5);
         m_c23s5_ff <= fk_pkg::mq(tr.c23, tr.s5);
         m_c4s1_ff  <= fk_pkg::mq(tr.c4, tr.s1);
         m_c1c23_ff <= fk_pkg::mq(tr.c1, tr.c23);
         m_s23s5_ff <= fk_pkg::mq(tr.s23, tr.s5);
         m_c4c6_ff  <= fk_pkg::mq(tr.c4, tr.c6);
         m_c5s4_ff  <= fk_pkg::mq(tr.c5, tr.s4);
         m_c6s4_ff  <= fk_pkg::mq(tr.c6, tr.s4);
         m_c4s5_ff  <= fk_pkg::mq(tr.c4, tr.s5);
         m_d6s1_ff  <= fk_pkg::mq(fk_pkg::K_D6, tr.s1);
         m_a2c2_ff  <= fk_pkg::mq(fk_pkg::K_A2, tr.c2);
         m_d6c23_ff <= fk_pkg::mq(fk_pkg::K_D6, tr.c23);
         m_c2s1_ff  <= fk_pkg::mq(tr.c2, tr.s1);
         m_d6c3_ff  <= fk_pkg::mq(fk_pkg::K_D6, tr.c3);
         m_a2s2_ff  <= fk_pkg::mq(fk_pkg::K_A2, tr.s2);
         m_d6c4_ff  <= fk_pkg::mq(fk_pkg::K_D6, tr.c4);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tr2_ff       <= tr1_ff;
         n_s1s4s5_ff  <= fk_pkg::mq(m_s1s4_ff, tr1_ff.s5);
         n_c23c4s5_ff <= fk_pkg::mq(m_c23c4_ff, tr1_ff.s5);
         n_c5s1s23_ff <= fk_pkg::mq(m_c5s1_ff, tr1_ff.s23);
         n_c23c4s1_ff <= fk_pkg::mq(m_c23c4_ff, tr1_ff.s1);
         n_c4s23s5_ff <= fk_pkg::mq(m_c4s23_ff, tr1_ff.s5);
         n_c6s23s4_ff <= fk_pkg::mq(m_c6s23_ff, tr1_ff.s4);
         n_c4c5s23_ff <= fk_pkg::mq(m_c4c5_ff, tr1_ff.s23);
         n_c1c23s4_ff <= fk_pkg::mq(m_c1c23_ff, tr1_ff.s4);
         n_c5s1s4_ff  <= fk_pkg::mq(m_c5s1_ff, tr1_ff.s4);
         n_c23c4c5_ff <= fk_pkg::mq(m_c23c4_ff, tr1_ff.c5);
         n_c5s4s6_ff  <= fk_pkg::mq(m_c5s4_ff, tr1_ff.s6);
         n_s23s5s6_ff <= fk_pkg::mq(m_s23s5_ff, tr1_ff.s6);
         n_c4s5s6_ff  <= fk_pkg::mq(m_c4s5_ff, tr1_ff.s6);
         n_d6s1s4_ff  <= fk_pkg::mq(m_d6s1_ff, tr1_ff.s4);
         n_rs23_ff    <= fk_pkg::mq(reach_ff, tr1_ff.s23);
         n_d6c23c4_ff <= fk_pkg::mq(m_d6c23_ff, tr1_ff.c4);
         n_c3r_ff     <= fk_pkg::mq(tr1_ff.c3, reach_ff);
         n_c4s1s2_ff  <= fk_pkg::mq(m_c4s1_ff, tr1_ff.s2);
         n_rs3_ff     <= fk_pkg::mq(reach_ff, tr1_ff.s3);
         n_d6c3c4_ff  <= fk_pkg::mq(m_d6c3_ff, tr1_ff.c4);
         n_c23r_ff    <= fk_pkg::mq(tr1_ff.c23, reach_ff);
         n_d6c4s23_ff <= fk_pkg::mq(m_d6c4_ff, tr1_ff.s23);
         n_c5s23_ff   <= m_c5s23_ff;
         n_c1s4_ff    <= m_c1s4_ff;
         n_c23c5_ff   <= m_c23c5_ff;
         n_c23s5_ff   <= m_c23s5_ff;
         n_c4s1_ff    <= m_c4s1_ff;
         n_s23s5_ff   <= m_s23s5_ff;
         n_c4c6_ff    <= m_c4c6_ff;
         n_c6s4_ff    <= m_c6s4_ff;
         n_a2c2_ff    <= m_a2c2_ff;
         n_c2s1_ff    <= m_c2s1_ff;
         n_a2s2_ff    <= m_a2s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tr3_ff        <= tr2_ff;
         o_r6b_ff      <= fk_pkg::mq(tr2_ff.c1, n_c5s23_ff + n_c23c4s5_ff);
         o_s1s4s5_ff   <= n_s1s4s5_ff;
         o_r7b_ff      <= fk_pkg::mq(n_c23c4s1_ff - n_c1s4_ff, tr2_ff.s5);
         o_c5s1s23_ff  <= n_c5s1s23_ff;
         o_r8_ff       <= n_c4s23s5_ff - n_c23c5_ff;
         o_r5b_ff      <= fk_pkg::mq(n_c4c5s23_ff + n_c23s5_ff, tr2_ff.s6);
         o_c6s23s4_ff  <= n_c6s23s4_ff;
         o_r3a_ff      <= fk_pkg::mq(tr2_ff.c6, n_c4s1_ff - n_c1c23s4_ff);
         o_r3c_ff      <= fk_pkg::mq(tr2_ff.c1, n_c23c4c5_ff - n_s23s5_ff);
         o_c5s1s4_ff   <= n_c5s1s4_ff;
         o_r4a_ff      <= fk_pkg::mq(tr2_ff.c1, n_c5s4s6_ff - n_c4c6_ff);
         o_r4c_ff      <= fk_pkg::mq(tr2_ff.c23, n_c6s4_ff + n_c4s5s6_ff);
         o_s23s5s6_ff  <= n_s23s5s6_ff;
         o_r0a_ff      <= fk_pkg::mq(n_d6s1s4_ff, tr2_ff.s5);
         o_r0c_ff      <= fk_pkg::mq(n_d6c23c4_ff, tr2_ff.s5);
         o_rs23_ff     <= n_rs23_ff;
         o_a2c2_ff     <= n_a2c2_ff;
         o_c3rs1_ff    <= fk_pkg::mq(n_c3r_ff, tr2_ff.s1);
         o_c4s1s2s3_ff <= fk_pkg::mq(n_c4s1s2_ff, tr2_ff.s3);
         o_c1s4_ff     <= n_c1s4_ff;
         o_r1c_ff      <= fk_pkg::mq(n_d6c3c4_ff, tr2_ff.s5);
         o_rs3_ff      <= n_rs3_ff;
         o_c2s1_ff     <= n_c2s1_ff;
         o_r2_ff       <= fk_pkg::K_D1 - n_c23r_ff + n_a2s2_ff
                          + fk_pkg::mq(n_d6c4s23_ff, tr2_ff.s5);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_4_ff  <= tr3_ff.s5;
         p_r0_ff  <= o_r0a_ff + fk_pkg::mq(tr3_ff.c1, o_a2c2_ff + o_rs23_ff + o_r0c_ff);
         p_r1a_ff <= fk_pkg::mq(o_c3rs1_ff, tr3_ff.s2);
         p_r1b_ff <= fk_pkg::mq(fk_pkg::K_D6, o_c4s1s2s3_ff + o_c1s4_ff);
         p_r1c_ff <= fk_pkg::mq(o_c2s1_ff, fk_pkg::K_A2 + o_rs3_ff + o_r1c_ff);
         p_r2_ff  <= o_r2_ff;
         p_r3_ff  <= o_r3a_ff - fk_pkg::mq(o_c5s1s4_ff + o_r3c_ff, tr3_ff.s6);
         p_r4_ff  <= o_r4a_ff - fk_pkg::mq(tr3_ff.s1, o_r4c_ff - o_s23s5s6_ff);
         p_r5_ff  <= -o_c6s23s4_ff - o_r5b_ff;
         p_r6_ff  <= o_s1s4s5_ff + o_r6b_ff;
         p_r7_ff  <= o_c5s1s23_ff + o_r7b_ff;
         p_r8_ff  <= o_r8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_r0_ff <= p_r0_ff;
         q_r1_ff <= p_r1a_ff - fk_pkg::mq(p_r1b_ff, s5_4_ff) + p_r1c_ff;
         q_r2_ff <= p_r2_ff;
         q_r3_ff <= p_r3_ff;
         q_r4_ff <= p_r4_ff;
         q_r5_ff <= p_r5_ff;
         q_r6_ff <= p_r6_ff;
         q_r7_ff <= p_r7_ff;
         q_r8_ff <= p_r8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pose_ff.pos_x      <= fk_pkg::to_q15(q_r0_ff);
         pose_ff.pos_y      <= fk_pkg::to_q15(q_r1_ff);
         pose_ff.pos_z      <= fk_pkg::to_q15(q_r2_ff);
         pose_ff.slide_x    <= fk_pkg::to_q15(q_r3_ff);
         pose_ff.slide_y    <= fk_pkg::to_q15(q_r4_ff);
         pose_ff.slide_z    <= fk_pkg::to_q15(q_r5_ff);
         pose_ff.approach_x <= fk_pkg::to_q15(q_r6_ff);
         pose_ff.approach_y <= fk_pkg::to_q15(q_r7_ff);
         pose_ff.approach_z <= fk_pkg::to_q15(q_r8_ff);
      end
   end

   assign pose = pose_ff;

endmodule

>>> rtl/six_axis_forward_kinematics.sv
// ----------------------------------------------------------------------------
// six_axis_forward_kinematics
// Joint commands in, gripper position with slide and approach vectors out.
// ----------------------------------------------------------------------------
//
//   Channel    Direction   Item
//   req_chan   in          six signed Q1.15 joint commands
//   rsp_chan   out         position, slide and approach, nine signed Q1.15
//
// One item is accepted per cycle while the skid register is empty, and each
// gives one result item; the 13 stages are an input phase register, six stages of
// the sine and cosine units and six stages of the pose multiplier tree.
// Reset is synchronous and clears only the valid bits of the pipeline, the
// output register and the skid register.
// When the result is not taken, the next result lands in the skid register and
// the whole pipeline then holds until the skid register drains.
//
module six_axis_forward_kinematics (
   input logic        clock,
   input logic        reset,
   fk_req_if.sink     req_chan,
   fk_rsp_if.source   rsp_chan
);

   // Pipeline advance: everything moves while the skid register is empty.
   logic adv;
   logic accept;
   logic pop;
   logic emit;

   logic [fk_pkg::PIPE_LAST:0] vld_ff;

   fk_pkg::phase_type ph_in [7];
   fk_pkg::phase_type ph_ff [7];

   fk_pkg::q_type    sin_v [7];
   fk_pkg::q_type    cos_v [7];
   fk_pkg::trig_type trig;
   fk_pkg::rsp_type  pose;

   logic            out_v_ff, out_v_in;
   logic            skid_v_ff, skid_v_in;
   fk_pkg::rsp_type out_ff;
   fk_pkg::rsp_type skid_ff;

   assign adv            = !skid_v_ff;
   assign req_chan.ready = adv;
   assign accept         = req_chan.valid && adv;
   assign pop            = out_v_ff && rsp_chan.ready;
   assign emit           = adv && vld_ff[fk_pkg::PIPE_LAST];

   // Joint commands map onto exact 18-bit phases: the offset joints flip the
   // sign bit, the elbow is negated and the roll joints span a full turn.
   always_comb begin
      ph_in[0] = {1'b0, ~req_chan.data.joint_one[15], req_chan.data.joint_one[14:0], 1'b0};
      ph_in[1] = {1'b0, ~req_chan.data.joint_two[15], req_chan.data.joint_two[14:0], 1'b0};
      ph_in[2] = 18'd0 - {req_chan.data.joint_three[15], req_chan.data.joint_three, 1'b0};
      ph_in[3] = {req_chan.data.joint_four, 2'b00};
      ph_in[4] = {1'b0, ~req_chan.data.joint_five[15], req_chan.data.joint_five[14:0], 1'b0};
      ph_in[5] = {req_chan.data.joint_six, 2'b00};
      ph_in[6] = ph_in[1] + ph_in[2];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph_ff <= ph_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[fk_pkg::PIPE_LAST-1:0], accept};
      end
   end

   // A sine and a cosine unit for each joint and for the shoulder-elbow sum.
   for (genvar g = 0; g < 7; g++) begin : g_trig
      fk_sincos u_sin (
         .clock (clock),
         .adv   (adv),
         .phase (ph_ff[g]),
         .value (sin_v[g])
      );
      fk_sincos u_cos (
         .clock (clock),
         .adv   (adv),
         .phase (ph_ff[g] + fk_pkg::QUARTER),
         .value (cos_v[g])
      );
   end

   always_comb begin
      trig.s1  = sin_v[0];  trig.c1  = cos_v[0];
      trig.s2  = sin_v[1];  trig.c2  = cos_v[1];
      trig.s3  = sin_v[2];  trig.c3  = cos_v[2];
      trig.s4  = sin_v[3];  trig.c4  = cos_v[3];
      trig.s5  = sin_v[4];  trig.c5  = cos_v[4];
      trig.s6  = sin_v[5];  trig.c6  = cos_v[5];
      trig.s23 = sin_v[6];  trig.c23 = cos_v[6];
   end

   fk_pose u_pose (
      .clock (clock),
      .adv   (adv),
      .tr    (trig),
      .pose  (pose)
   );

   // Output register with a one-entry skid behind it.
   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         if (pop) begin
            skid_v_in = 1'b0;
         end
      end else if (emit) begin
         if (out_v_ff && !pop) begin
            skid_v_in = 1'b1;
         end else begin
            out_v_in = 1'b1;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (emit) begin
         if (out_v_ff && !pop) begin
            skid_ff <= pose;
         end else begin
            out_ff <= pose;
         end
      end
   end

   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.data  = out_ff;

`ifndef SYNTH
   a_skid_needs_out : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register holds an item while the output register is empty");

   a_skid_holds : assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !rsp_chan.ready) |=> skid_v_ff)
      else $error("skid register item lost while the output stalls");

   a_spill : assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_chan.ready && !skid_v_ff && vld_ff[fk_pkg::PIPE_LAST])
      |=> (skid_v_ff && out_v_ff))
      else $error("finished item not captured while the output stalls");

   a_reset_clear : assert property (@(posedge clock)
      $past(reset) |-> (!out_v_ff && !skid_v_ff && (vld_ff == '0)))
      else $error("valid state not cleared by reset");
`endif

endmodule

>>> bench/six_axis_forward_kinematics_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// six_axis_forward_kinematics_tb
// Self-checking bench for the arm forward kinematics pipeline. Joint vectors
// are sent under several idling patterns, each pose that comes back is
// compared field by field with a pose worked out in the bench itself.
// ----------------------------------------------------------------------------
module six_axis_forward_kinematics_tb;

   typedef logic signed [63:0] wide_type;

   localparam wide_type ONE_Q30 = 64'sd1073741824;
   localparam wide_type LEN_D1  = (64'sd125 * ONE_Q30 + 64'sd293) / 64'sd587;
   localparam wide_type LEN_A2  = (64'sd150 * ONE_Q30 + 64'sd293) / 64'sd587;
   localparam wide_type LEN_D4  = (64'sd192 * ONE_Q30 + 64'sd293) / 64'sd587;
   localparam wide_type LEN_D6  = (64'sd120 * ONE_Q30 + 64'sd293) / 64'sd587;
   localparam logic [63:0] POLY_C1 = 64'd1686629713;
   localparam logic [63:0] POLY_C3 = 64'd693598668;
   localparam logic [63:0] POLY_C5 = 64'd85569306;
   localparam logic [63:0] POLY_C7 = 64'd5026995;
   localparam logic [63:0] POLY_C9 = 64'd172272;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fk_req_if req_chan ();
   fk_rsp_if rsp_chan ();

   six_axis_forward_kinematics uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Expected poses in the order their joint vectors were accepted.
   fk_pkg::rsp_type pose_queue[$];
   int      mismatch_count = 0;
   int      pose_count = 0;
   int      joint_count = 0;

   // Idling percentages, changed from phase to phase.
   int      send_idle_pct = 0;
   int      take_stall_pct = 0;
   bit      hold_off = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Pose predictor: all arithmetic in 64-bit signed Q30, with products
   // floored back to Q30, just as the hardware does it.
   // ------------------------------------------------------------------------
   function automatic wide_type mul_q30(wide_type a, wide_type b);
      return (a * b) >>> 30;
   endfunction

   function automatic wide_type sine_of(logic [17:0] ph);
      logic [63:0] f;
      logic [63:0] x2;
      logic [63:0] r;
      wide_type    v;
      f = {48'd0, ph[15:0]};
      if (ph[16]) begin
         f = 64'd65536 - f;
      end
      x2 = (f * f) >> 16;
      r  = POLY_C9;
      r  = POLY_C7 - ((r * x2) >> 16);
      r  = POLY_C5 - ((r * x2) >> 16);
      r  = POLY_C3 - ((r * x2) >> 16);
      r  = POLY_C1 - ((r * x2) >> 16);
      v  = wide_type'((r * f) >> 16);
      return ph[17] ? -v : v;
   endfunction

   function automatic wide_type cosine_of(logic [17:0] ph);
      return sine_of(ph + 18'h10000);
   endfunction

   function automatic logic signed [15:0] q30_to_q15(wide_type v);
      wide_type t;
      t = (v + 64'sd16384) >>> 15;
      if (t > 64'sd32767) begin
         return 16'sh7fff;
      end
      if (t < -64'sd32768) begin
         return 16'sh8000;
      end
      return t[15:0];
   endfunction

   function automatic fk_pkg::rsp_type predict_pose(fk_pkg::req_type j);
      logic [17:0] p1, p2, p3, p4, p5, p6, p23;
      wide_type s1, c1, s2, c2, s3, c3, s4, c4, s5, c5, s6, c6, s23, c23;
      wide_type reach;
      fk_pkg::rsp_type pose;
      // Commands map onto 18-bit phases; a full turn is 2^18.
      p1  = 18'({j.joint_one[15] ? 2'b00 : 2'b01, j.joint_one[14:0], 1'b0});
      p2  = 18'({j.joint_two[15] ? 2'b00 : 2'b01, j.joint_two[14:0], 1'b0});
      p3  = 18'(-(32'(j.joint_three) * 2));
      p4  = 18'(32'(j.joint_four) * 4);
      p5  = 18'({j.joint_five[15] ? 2'b00 : 2'b01, j.joint_five[14:0], 1'b0});
      p6  = 18'(32'(j.joint_six) * 4);
      p23 = p2 + p3;
      s1 = sine_of(p1);   c1 = cosine_of(p1);
      s2 = sine_of(p2);   c2 = cosine_of(p2);
      s3 = sine_of(p3);   c3 = cosine_of(p3);
      s4 = sine_of(p4);   c4 = cosine_of(p4);
      s5 = sine_of(p5);   c5 = cosine_of(p5);
      s6 = sine_of(p6);   c6 = cosine_of(p6);
      s23 = sine_of(p23); c23 = cosine_of(p23);
      reach = LEN_D4 + mul_q30(LEN_D6, c5);

      pose.pos_x = q30_to_q15(
         mul_q30(mul_q30(mul_q30(LEN_D6, s1), s4), s5)
         + mul_q30(c1, mul_q30(LEN_A2, c2) + mul_q30(reach, s23)
                   + mul_q30(mul_q30(mul_q30(LEN_D6, c23), c4), s5)));
      pose.pos_y = q30_to_q15(
         mul_q30(mul_q30(mul_q30(c3, reach), s1), s2)
         - mul_q30(mul_q30(LEN_D6, mul_q30(mul_q30(mul_q30(c4, s1), s2), s3)
                                   + mul_q30(c1, s4)), s5)
         + mul_q30(mul_q30(c2, s1), LEN_A2 + mul_q30(reach, s3)
                   + mul_q30(mul_q30(mul_q30(LEN_D6, c3), c4), s5)));
      pose.pos_z = q30_to_q15(
         LEN_D1 - mul_q30(c23, reach) + mul_q30(LEN_A2, s2)
         + mul_q30(mul_q30(mul_q30(LEN_D6, c4), s23), s5));

      pose.slide_x = q30_to_q15(
         mul_q30(c6, mul_q30(c4, s1) - mul_q30(mul_q30(c1, c23), s4))
         - mul_q30(mul_q30(mul_q30(c5, s1), s4)
                   + mul_q30(c1, mul_q30(mul_q30(c23, c4), c5) - mul_q30(s23, s5)), s6));
      pose.slide_y = q30_to_q15(
         mul_q30(c1, -mul_q30(c4, c6) + mul_q30(mul_q30(c5, s4), s6))
         - mul_q30(s1, -mul_q30(mul_q30(s23, s5), s6)
                   + mul_q30(c23, mul_q30(c6, s4) + mul_q30(mul_q30(c4, s5), s6))));
      pose.slide_z = q30_to_q15(
         -mul_q30(mul_q30(c6, s23), s4)
         - mul_q30(mul_q30(mul_q30(c4, c5), s23) + mul_q30(c23, s5), s6));

      pose.approach_x = q30_to_q15(
         mul_q30(mul_q30(s1, s4), s5)
         + mul_q30(c1, mul_q30(c5, s23) + mul_q30(mul_q30(c23, c4), s5)));
      pose.approach_y = q30_to_q15(
         mul_q30(mul_q30(c5, s1), s23)
         + mul_q30(mul_q30(mul_q30(c23, c4), s1) - mul_q30(c1, s4), s5));
      pose.approach_z = q30_to_q15(
         -mul_q30(c23, c5) + mul_q30(mul_q30(c4, s23), s5));
      return pose;
   endfunction

   // ------------------------------------------------------------------------
   // Sending side. The valid is only lowered when an idle cycle follows, so
   // it never gets two assignments in one step.
   // ------------------------------------------------------------------------
   initial begin
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
   end

   task automatic send_joints(input fk_pkg::req_type j);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= j;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      pose_queue.push_back(predict_pose(j));
      joint_count++;
   endtask

   task automatic end_burst();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic fk_pkg::req_type random_joints();
      fk_pkg::req_type j;
      j = fk_pkg::req_type'({$urandom, $urandom, $urandom});
      // Now and again pin a joint at either end of its range.
      if ($urandom_range(7, 0) == 0) begin
         j.joint_two = $urandom_range(1, 0) ? 16'sh8000 : 16'sh7fff;
      end
      if ($urandom_range(7, 0) == 0) begin
         j.joint_five = $urandom_range(1, 0) ? 16'sh8000 : 16'sh7fff;
      end
      return j;
   endfunction

   // ------------------------------------------------------------------------
   // Receiving side: ready is redrawn every cycle, and held low throughout
   // a hold-off.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99, 0) >= take_stall_pct);
      end
   end

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: pose %0d field %s: got %0d, expected %0d", $realtime,
               pose_count, field, $signed(got), $signed(want));
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      fk_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pose_queue.size() == 0) begin
            $display("%0t: pose arrived with none outstanding", $realtime);
            mismatch_count++;
         end else begin
            want = pose_queue.pop_front();
            if (rsp_chan.data.pos_x !== want.pos_x)
               report_mismatch("pos_x", rsp_chan.data.pos_x, want.pos_x);
            if (rsp_chan.data.pos_y !== want.pos_y)
               report_mismatch("pos_y", rsp_chan.data.pos_y, want.pos_y);
            if (rsp_chan.data.pos_z !== want.pos_z)
               report_mismatch("pos_z", rsp_chan.data.pos_z, want.pos_z);
            if (rsp_chan.data.slide_x !== want.slide_x)
               report_mismatch("slide_x", rsp_chan.data.slide_x, want.slide_x);
            if (rsp_chan.data.slide_y !== want.slide_y)
               report_mismatch("slide_y", rsp_chan.data.slide_y, want.slide_y);
            if (rsp_chan.data.slide_z !== want.slide_z)
               report_mismatch("slide_z", rsp_chan.data.slide_z, want.slide_z);
            if (rsp_chan.data.approach_x !== want.approach_x)
               report_mismatch("approach_x", rsp_chan.data.approach_x, want.approach_x);
            if (rsp_chan.data.approach_y !== want.approach_y)
               report_mismatch("approach_y", rsp_chan.data.approach_y, want.approach_y);
            if (rsp_chan.data.approach_z !== want.approach_z)
               report_mismatch("approach_z", rsp_chan.data.approach_z, want.approach_z);
         end
         pose_count++;
      end
   end

   task automatic wait_for_poses();
      while (pose_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Joint extremes, the zero command and single-bit walks so that every
   // bit of every joint is seen both ways.
   task automatic test_directed();
      fk_pkg::req_type j;
      logic signed [15:0] ends[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
      for (int k = 0; k < 4; k++) begin
         j = {6{ends[k]}};
         send_joints(j);
      end
      // Lowest command on one joint at a time, the rest at full scale.
      for (int k = 0; k < 6; k++) begin
         j = {6{16'sh7fff}};
         j[16 * k +: 16] = 16'sh8000;
         send_joints(j);
      end
      // Quarter turns, where the unit vectors reach exactly one.
      send_joints({16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000, 16'shc000, 16'sh4000});
      send_joints({16'sh4000, 16'sh8000, 16'sh4000, 16'sh0000, 16'sh0000, 16'shc000});
      for (int b = 0; b < 13; b++) begin
         j = fk_pkg::req_type'({6{16'(1) << b}} | {6{16'(1) << (b + 3)}});
         send_joints(j);
      end
      end_burst();
   endtask

   task automatic test_random(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      take_stall_pct = stall_pct;
      for (int k = 0; k < count; k++) begin
         send_joints(random_joints());
         // A few stretches of back-to-back items inside idling phases.
         if (idle_pct != 0 && $urandom_range(19, 0) == 0) begin
            send_idle_pct = 0;
            repeat ($urandom_range(8, 2)) send_joints(random_joints());
            send_idle_pct = idle_pct;
         end
      end
      end_burst();
   endtask

   // The receiver holds off while items keep coming, so the pipeline fills
   // and must stall its input; then the sender waits for everything to drain.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      take_stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            repeat (40) send_joints(random_joints());
            end_burst();
         end
      join
      wait_for_poses();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(200, 0, 0);
      test_random(140, 88, 0);
      test_random(140, 0, 88);
      test_random(140, 33, 33);
      test_backpressure();
      test_random(100, 0, 0);

      wait_for_poses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d joint vectors and checked %0d poses, with idle and stall", joint_count,
               pose_count);
      $display("phases, a long output hold-off and joint extremes on every axis.");
      if (mismatch_count == 0 && pose_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5ms;
      $display("Timed out with %0d poses outstanding", pose_queue.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
